[hw/rtl/assert_macros.svh]
// assertion macros used by utf8_stream_decoder_unit
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/utf8sd_pkg.sv]
// types and constants of the utf-8 stream decoder
// no dependencies
`default_nettype none

package utf8sd_pkg;

  typedef logic [7:0]       byte_t;
  typedef logic [20:0]      cp_t;
  typedef logic [3:0][7:0]  win_t;

  typedef struct packed {
    logic       short_seq;
    logic       repl;
    logic [2:0] len;
    cp_t        cp;
  } dec_t;

  localparam byte_t LEAD2_MASK = 8'hE0;
  localparam byte_t LEAD2_VAL  = 8'hC0;
  localparam byte_t LEAD3_MASK = 8'hF0;
  localparam byte_t LEAD3_VAL  = 8'hE0;
  localparam byte_t LEAD4_MASK = 8'hF8;
  localparam byte_t LEAD4_VAL  = 8'hF0;
  localparam byte_t CONT_MASK  = 8'hC0;
  localparam byte_t CONT_VAL   = 8'h80;

  localparam cp_t MIN2      = 21'h000080;
  localparam cp_t MIN3      = 21'h000800;
  localparam cp_t MIN4      = 21'h010000;
  localparam cp_t CP_MAX    = 21'h10FFFF;
  localparam cp_t SURR_LO   = 21'h00D800;
  localparam cp_t SURR_HI   = 21'h00DFFF;
  localparam cp_t REPL_CHAR = 21'h00FFFD;

endpackage

`default_nettype wire

[hw/rtl/utf8sd_decode.sv]
// sequence decoder: classifies and decodes one sequence at the window head
// depends on utf8sd_pkg
`default_nettype none

module utf8sd_decode (
  input  utf8sd_pkg::win_t win,
  input  logic [2:0]       avail,
  output utf8sd_pkg::dec_t dec
);
  import utf8sd_pkg::*;

  byte_t lead;
  cp_t   cp2;
  cp_t   cp3;
  cp_t   cp4;
  logic  c1ok;
  logic  c2ok;
  logic  c3ok;

  assign lead = win[0];
  assign cp2  = {10'd0, lead[4:0], win[1][5:0]};
  assign cp3  = {5'd0, lead[3:0], win[1][5:0], win[2][5:0]};
  assign cp4  = {lead[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
  assign c1ok = (win[1] & CONT_MASK) == CONT_VAL;
  assign c2ok = (win[2] & CONT_MASK) == CONT_VAL;
  assign c3ok = (win[3] & CONT_MASK) == CONT_VAL;

  always_comb begin
    dec.short_seq = 1'b0;
    dec.repl      = 1'b1;
    dec.len       = 3'd1;
    dec.cp        = REPL_CHAR;
    if (!lead[7]) begin
      dec.repl = 1'b0;
      dec.cp   = {13'd0, lead};
    end else if ((lead & LEAD2_MASK) == LEAD2_VAL) begin
      if (avail < 3'd2) begin
        dec.short_seq = 1'b1;
      end else if (c1ok && cp2 >= MIN2) begin
        dec.repl = 1'b0;
        dec.len  = 3'd2;
        dec.cp   = cp2;
      end
    end else if ((lead & LEAD3_MASK) == LEAD3_VAL) begin
      if (avail < 3'd3) begin
        dec.short_seq = 1'b1;
      end else if (c1ok && c2ok && cp3 >= MIN3 && !(cp3 >= SURR_LO && cp3 <= SURR_HI)) begin
        dec.repl = 1'b0;
        dec.len  = 3'd3;
        dec.cp   = cp3;
      end
    end else if ((lead & LEAD4_MASK) == LEAD4_VAL) begin
      if (avail < 3'd4) begin
        dec.short_seq = 1'b1;
      end else if (c1ok && c2ok && c3ok && cp4 >= MIN4 && cp4 <= CP_MAX) begin
        dec.repl = 1'b0;
        dec.len  = 3'd4;
        dec.cp   = cp4;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/utf8_stream_decoder_unit.sv]
// Decodes a UTF-8 byte stream into Unicode code points, substituting U+FFFD for
// malformed input; after a bad sequence only its lead byte is dropped and the
// following bytes are decoded again; a sequence cut short by end of text yields
// one U+FFFD for all its bytes. A byte holds the block until its results reach
// the output register; the single sequence decoder takes one sequence per cycle
// unless the output stalls. in_tready is low while a byte is being worked on.
// Results leave through a registered output stage. No clearing pass after reset.
// Depends on utf8sd_pkg, utf8sd_decode and assert_macros.svh.
`default_nettype none

module utf8_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tlast,  // last_of_run
  output logic [1:0]  out_tuser   // [0] replaced, [1] text_done
);
  import utf8sd_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t     state_r, state_nxt;
  byte_t      buf_r [4];
  byte_t      buf_nxt [4];
  logic [2:0] n_r, n_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       eot_r, eot_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  cp_t        pend_cp_r, pend_cp_nxt;
  logic       pend_repl_r, pend_repl_nxt;
  logic       out_valid_r, out_valid_nxt;
  cp_t        out_cp_r, out_cp_nxt;
  logic       out_repl_r, out_repl_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_done_r, out_done_nxt;

  win_t       win;
  logic [2:0] avail;
  dec_t       dec;
  logic       at_end;
  logic       step_emit;
  cp_t        step_cp;
  logic       step_repl;
  logic [2:0] pos_adv;
  logic       out_free;
  logic       can_go;

  // window of buffered bytes starting at the scan position
  always_comb begin
    logic [3:0] k;
    for (int i = 0; i < 4; i++) begin
      k = {1'b0, pos_r} + 4'(i);
      win[i] = (k < 4'd4) ? buf_r[k[1:0]] : 8'h00;
    end
  end

  assign avail = n_r - pos_r;

  utf8sd_decode u_decode (
    .win   (win),
    .avail (avail),
    .dec   (dec)
  );

  assign at_end    = pos_r >= n_r;
  assign step_emit = !at_end && (!dec.short_seq || eot_r);
  assign step_cp   = dec.short_seq ? REPL_CHAR : dec.cp;
  assign step_repl = dec.short_seq | dec.repl;
  assign pos_adv   = dec.short_seq ? n_r : pos_r + dec.len;
  assign out_free  = !out_valid_r || out_tready;
  assign can_go    = !pend_valid_r || out_free;

  always_comb begin
    logic [3:0] k;
    state_nxt      = state_r;
    buf_nxt        = buf_r;
    n_nxt          = n_r;
    pos_nxt        = pos_r;
    eot_nxt        = eot_r;
    pend_valid_nxt = pend_valid_r;
    pend_cp_nxt    = pend_cp_r;
    pend_repl_nxt  = pend_repl_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cp_nxt     = out_cp_r;
    out_repl_nxt   = out_repl_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    k              = 4'd0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          buf_nxt[n_r[1:0]] = in_tdata;
          n_nxt     = n_r + 3'd1;
          pos_nxt   = 3'd0;
          eot_nxt   = in_tlast;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (can_go) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_cp_nxt     = pend_cp_r;
            out_repl_nxt   = pend_repl_r;
            out_last_nxt   = !step_emit;
            out_done_nxt   = !step_emit && eot_r;
            pend_valid_nxt = 1'b0;
          end
          if (step_emit) begin
            pend_valid_nxt = 1'b1;
            pend_cp_nxt    = step_cp;
            pend_repl_nxt  = step_repl;
            pos_nxt        = pos_adv;
          end else begin
            // keep the unfinished tail at the front of the buffer
            n_nxt = eot_r ? 3'd0 : n_r - pos_r;
            for (int i = 0; i < 3; i++) begin
              k = {1'b0, pos_r} + 4'(i);
              if (k < 4'd4) begin
                buf_nxt[i] = buf_r[k[1:0]];
              end
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      n_r          <= 3'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    buf_r       <= buf_nxt;
    pos_r       <= pos_nxt;
    eot_r       <= eot_nxt;
    pend_cp_r   <= pend_cp_nxt;
    pend_repl_r <= pend_repl_nxt;
    out_cp_r    <= out_cp_nxt;
    out_repl_r  <= out_repl_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_cp_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_done_r, out_repl_r};

  `ASSERT_SAME(a_repl_value, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[20:0] == REPL_CHAR)
  `ASSERT_SAME(a_done_is_last, clk, rst_n, out_tvalid && out_tuser[1], out_tlast)
  `ASSERT_SAME(a_idle_no_pend, clk, rst_n, state_r == ST_IDLE, !pend_valid_r && n_r <= 3'd3)
  `ASSERT_NEXT(a_accept_scans, clk, rst_n, in_tvalid && in_tready, state_r == ST_SCAN && pos_r == 3'd0)

endmodule

`default_nettype wire

[test/utf8_stream_decoder_unit_tb.sv]
// self-checking testbench for utf8_stream_decoder_unit: byte stream in, code points out
// expected code points come from a decoder model kept inside the bench
// depends on utf8sd_pkg and utf8_stream_decoder_unit

module utf8_stream_decoder_unit_tb;
  import utf8sd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    cp_t  code_point;
    logic replaced;
    logic last_of_run;
    logic text_done;
  } cp_result_t;

  typedef enum {
    SEQ_VALID, SEQ_OVERLONG, SEQ_SURROGATE, SEQ_TOO_HIGH,
    SEQ_TRUNCATED, SEQ_CORRUPT, SEQ_NOISE
  } seq_kind_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] byte_value
  logic        in_tlast = 1'b0;    // end_of_text
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [20:0] code_point, [23:21] zero
  logic        out_tlast;          // last_of_run
  logic [1:0]  out_tuser;          // [0] replaced, [1] text_done

  cp_result_t  expected_cps[$];
  byte_t       pend_bytes[3];
  int unsigned pend_len = 0;
  int unsigned bytes_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;

  utf8_stream_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[utf8_stream_decoder_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99, 0) >= 33);
  end

  // model of the decoder: held bytes plus the new byte are scanned from the front
  task automatic decode_byte(input byte_t value, input bit eot);
    byte_t       win[4];
    byte_t       lead;
    cp_result_t  run[4];
    int unsigned n, pos, len, i, cnt;
    cp_t         cp, minv;
    bit          ok;
    n = pend_len;
    cnt = 0;
    pos = 0;
    for (i = 0; i < n; i++) win[i] = pend_bytes[i];
    win[n] = value;
    n++;
    while (pos < n) begin
      lead = win[pos];
      ok = 1'b1;
      if (lead < 8'h80) begin
        cp = cp_t'(lead);
        len = 1;
        minv = '0;
      end else if ((lead & LEAD2_MASK) == LEAD2_VAL) begin
        cp = cp_t'(lead & 8'h1F);
        len = 2;
        minv = MIN2;
      end else if ((lead & LEAD3_MASK) == LEAD3_VAL) begin
        cp = cp_t'(lead & 8'h0F);
        len = 3;
        minv = MIN3;
      end else if ((lead & LEAD4_MASK) == LEAD4_VAL) begin
        cp = cp_t'(lead & 8'h07);
        len = 4;
        minv = MIN4;
      end else begin
        run[cnt] = '{REPL_CHAR, 1'b1, 1'b0, 1'b0};
        cnt++;
        pos++;
        continue;
      end
      if (n - pos < len) begin
        if (eot) begin
          run[cnt] = '{REPL_CHAR, 1'b1, 1'b0, 1'b0};
          cnt++;
          pos = n;
        end
        break;
      end
      for (i = 1; i < len; i++) begin
        if ((win[pos + i] & CONT_MASK) != CONT_VAL) begin
          ok = 1'b0;
          break;
        end
        cp = (cp << 6) | (win[pos + i] & 8'h3F);
      end
      if (!ok || cp < minv || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
        run[cnt] = '{REPL_CHAR, 1'b1, 1'b0, 1'b0};
        cnt++;
        pos++;
        continue;
      end
      run[cnt] = '{cp, 1'b0, 1'b0, 1'b0};
      cnt++;
      pos += len;
    end
    if (eot || pos >= n) begin
      pend_len = 0;
    end else begin
      pend_len = n - pos;
      for (i = 0; i < pend_len; i++) pend_bytes[i] = win[pos + i];
    end
    if (cnt > 0) begin
      run[cnt - 1].last_of_run = 1'b1;
      run[cnt - 1].text_done = eot;
    end
    for (i = 0; i < cnt; i++) expected_cps = {expected_cps, run[i]};
  endtask

  task automatic send_byte(input byte_t value, input bit eot);
    int unsigned gap;
    gap = 0;
    if (!steady) while ($urandom_range(99, 0) < 33) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tlast <= eot;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    decode_byte(value, eot);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_cps.size() != 0);
  endtask

  function automatic win_t encode_scalar(input cp_t cp, input int unsigned len);
    win_t w;
    w = '0;
    case (len)
      1: w[0] = cp[7:0];
      2: begin
        w[0] = {3'b110, cp[10:6]};
        w[1] = {2'b10, cp[5:0]};
      end
      3: begin
        w[0] = {4'b1110, cp[15:12]};
        w[1] = {2'b10, cp[11:6]};
        w[2] = {2'b10, cp[5:0]};
      end
      default: begin
        w[0] = {5'b11110, cp[20:18]};
        w[1] = {2'b10, cp[17:12]};
        w[2] = {2'b10, cp[11:6]};
        w[3] = {2'b10, cp[5:0]};
      end
    endcase
    return w;
  endfunction

  function automatic cp_t random_scalar(input int unsigned len);
    cp_t cp;
    case (len)
      1: cp = cp_t'($urandom_range(21'h7F, 0));
      2: cp = cp_t'($urandom_range(21'h7FF, MIN2));
      3: begin
        cp = cp_t'($urandom_range(21'hFFFF, MIN3));
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h1000;
      end
      default: cp = cp_t'($urandom_range(CP_MAX, MIN4));
    endcase
    return cp;
  endfunction

  task automatic send_random_sequence();
    seq_kind_t   kind;
    win_t        w;
    cp_t         cp;
    int unsigned pick, len, count, i;
    bit          eot;
    pick = $urandom_range(99, 0);
    kind = pick < 62 ? SEQ_VALID : pick < 67 ? SEQ_OVERLONG : pick < 72 ? SEQ_SURROGATE :
           pick < 77 ? SEQ_TOO_HIGH : pick < 85 ? SEQ_TRUNCATED :
           pick < 92 ? SEQ_CORRUPT : SEQ_NOISE;
    len = $urandom_range(4, 1);
    if ((kind == SEQ_TRUNCATED || kind == SEQ_CORRUPT) && len == 1) len = 2;
    case (kind)
      SEQ_OVERLONG: begin
        len = $urandom_range(4, 2);
        cp = cp_t'(len == 2 ? $urandom_range(21'h7F, 0) :
                   len == 3 ? $urandom_range(21'h7FF, 0) : $urandom_range(21'hFFFF, 0));
      end
      SEQ_SURROGATE: begin
        len = 3;
        cp = cp_t'($urandom_range(SURR_HI, SURR_LO));
      end
      SEQ_TOO_HIGH: begin
        len = 4;
        cp = cp_t'($urandom_range(21'h1FFFFF, CP_MAX + 1));
      end
      default: cp = random_scalar(len);
    endcase
    w = encode_scalar(cp, len);
    count = len;
    if (kind == SEQ_TRUNCATED) count = $urandom_range(len - 1, 1);
    if (kind == SEQ_CORRUPT) w[$urandom_range(len - 1, 1)] = byte_t'($urandom_range(255, 0));
    if (kind == SEQ_NOISE) begin
      w[0] = byte_t'($urandom_range(255, 0));
      count = 1;
    end
    eot = $urandom_range(99, 0) < 8;
    for (i = 0; i < count; i++) send_byte(w[i], eot && i == count - 1);
  endtask

  task automatic test_random_text(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_sequence();
  endtask

  task automatic test_ascii_bounds();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte_bounds();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // overlong, surrogate, out-of-range and bad-continuation forms, each rescanned after the lead
  task automatic test_rejected_forms();
    send_byte(8'hC0, 1'b0);
    send_byte(8'hAF, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_invalid_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF8, 1'b0);
  endtask

  task automatic test_truncated_text();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    hold_until_drained();
    test_random_text(60);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    test_random_text(90);
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    cp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cps.size() == 0) begin
        $error("unexpected result: code_point %h", out_tdata[20:0]);
        fail_count++;
      end else begin
        want = expected_cps.pop_front();
        if (out_tdata[20:0] !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, out_tdata[20:0]);
          fail_count++;
        end
        if (out_tuser[0] !== want.replaced) begin
          $error("replaced: expected %b, got %b", want.replaced, out_tuser[0]);
          fail_count++;
        end
        if (out_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, out_tlast);
          fail_count++;
        end
        if (out_tuser[1] !== want.text_done) begin
          $error("text_done: expected %b, got %b", want.text_done, out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ascii_bounds();
    test_multibyte_bounds();
    test_rejected_forms();
    test_invalid_leads();
    test_truncated_text();
    test_random_text(125);
    test_pause_until_drained();
    test_back_to_back();
    test_random_text(80);
    hold_until_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[utf8_stream_decoder_unit] OK");
    end else begin
      $display("[utf8_stream_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_decode.sv
hw/rtl/utf8_stream_decoder_unit.sv
test/utf8_stream_decoder_unit_tb.sv
